// File: hw/rtl/vrlf_pkg.sv
// ----------------------------------------------------------------------------
// vrlf_pkg
// Shared constants, types and helpers of the voxel run-length loader with
// face culling.
// ----------------------------------------------------------------------------
package vrlf_pkg;

  localparam int CHUNK_EDGE  = 16;
  localparam int LAYER_COUNT = 16;

  localparam int XW   = $clog2(CHUNK_EDGE);
  localparam int ZW   = $clog2(LAYER_COUNT);
  localparam int ROWS = CHUNK_EDGE * LAYER_COUNT;
  localparam int AW   = $clog2(ROWS);

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_CHAR  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_AIR   = 8'h61;
  localparam logic [7:0] CH_SOLID = 8'h73;
  localparam logic [7:0] RUN_MAX  = 8'd255;

  localparam logic [2:0] Q_CENTER = 3'd0;
  localparam logic [2:0] Q_YM     = 3'd1;
  localparam logic [2:0] Q_YP     = 3'd2;
  localparam logic [2:0] Q_ZM     = 3'd3;
  localparam logic [2:0] Q_ZP     = 3'd4;
  localparam logic [2:0] QSTEPS   = 3'd5;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_QUERY,
    S_EMIT
  } state_t;

  typedef logic [CHUNK_EDGE-1:0] row_t;
  typedef logic [AW-1:0] addr_t;

  typedef struct packed {
    logic [5:0] face_mask;
    logic       solid;
    logic       layers_done;
    logic       format_error;
  } result_t;

  // One memory word holds one x row of the chunk.
  function automatic addr_t row_addr(input int unsigned y, input int unsigned z);
    return AW'(z * CHUNK_EDGE + y);
  endfunction

endpackage

// File: hw/rtl/voxel_rle_load_face_cull_unit.sv
// ----------------------------------------------------------------------------
// voxel_rle_load_face_cull_unit
// Run-length voxel chunk loader with six-face visibility queries.
// ----------------------------------------------------------------------------
// The chunk is held as one memory word per x row, so every store access is a
// single row read or write on a one-read, one-write port. After reset the
// block clears the store to air row by row and stalls its input meanwhile.
// Each item gives exactly one result item. A start command, a digit or an
// ignored character goes straight to its result, a run letter that writes
// passes through a row read, a merged row write and the result, and a query
// makes its five row reads through the single read port, captures the last
// row and then gives its result. A result waiting in the output register does
// not keep the next item from being accepted.
module voxel_rle_load_face_cull_unit
  import vrlf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [7:0] code_char,
  input  logic [3:0] query_x,
  input  logic [3:0] query_y,
  input  logic [3:0] query_z,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] face_mask,
  output logic       solid,
  output logic       layers_done,
  output logic       format_error
);

  logic    res_valid;
  logic    res_ready;
  result_t res;

  vrlf_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .code_char(code_char),
    .query_x  (query_x),
    .query_y  (query_y),
    .query_z  (query_z),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      face_mask    <= res.face_mask;
      solid        <= res.solid;
      layers_done  <= res.layers_done;
      format_error <= res.format_error;
    end
  end

endmodule

// File: hw/rtl/vrlf_ram.sv
// ----------------------------------------------------------------------------
// vrlf_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module vrlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/vrlf_core.sv
// ----------------------------------------------------------------------------
// vrlf_core
// Command sequencer: decodes run-length characters, writes runs into the
// row store by read-modify-write, and gathers the neighbor rows of a query.
// ----------------------------------------------------------------------------
module vrlf_core
  import vrlf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [7:0] code_char,
  input  logic [3:0] query_x,
  input  logic [3:0] query_y,
  input  logic [3:0] query_z,
  output logic       res_valid,
  input  logic       res_ready,
  output result_t    res
);

  state_t state, state_next;

  logic [XW-1:0] fill_x;
  logic [XW-1:0] fill_y;
  logic [ZW-1:0] fill_layer;
  logic [7:0]    run_count;
  logic          done_flag;
  logic          error_flag;
  addr_t         clr_addr;
  logic [2:0]    qstep;
  logic          rd_live;
  logic [2:0]    rd_sel;

  logic          run_kind;
  logic [7:0]    run_len;
  logic [3:0]    qx, qy, qz;
  logic          is_query;
  logic          solid_c;
  logic          nb_xm, nb_xp, nb_ym, nb_yp, nb_zm, nb_zp;

  logic          accept;
  logic          is_digit;
  logic          is_run;
  logic [11:0]   digit_sum;
  logic [7:0]    digit_next;
  logic          overrun;
  logic          start_write;
  int unsigned   fill_end;
  addr_t         fill_row;
  row_t          merged;

  logic          ram_we;
  addr_t         ram_waddr;
  row_t          ram_wdata;
  addr_t         ram_raddr;
  row_t          ram_rdata;

  logic [XW-1:0] xi, xm, xp;
  logic          c_in, xm_in, xp_in, ym_in, yp_in, zm_in, zp_in;

  vrlf_ram #(
    .WIDTH(CHUNK_EDGE),
    .DEPTH(ROWS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign accept   = in_valid && (state == S_IDLE);
  assign fill_row = row_addr(32'(fill_y), 32'(fill_layer));
  assign fill_end = 32'(fill_x) + 32'(run_len);

  always_comb begin
    is_digit    = code_char inside {[CH_ZERO:CH_NINE]};
    is_run      = (code_char == CH_SOLID) || (code_char == CH_AIR);
    digit_sum   = {1'b0, run_count, 3'b000} + {3'b000, run_count, 1'b0}
                  + 12'(code_char - CH_ZERO);
    digit_next  = (digit_sum > 12'(RUN_MAX)) ? RUN_MAX : digit_sum[7:0];
    overrun     = (32'(fill_x) + 32'(run_count)) > CHUNK_EDGE;
    start_write = (cmd == CMD_CHAR) && is_run && !done_flag && !overrun
                  && (run_count != 8'd0);
  end

  always_comb begin
    for (int i = 0; i < CHUNK_EDGE; i++) begin
      if ((i >= 32'(fill_x)) && (i < fill_end)) begin
        merged[i] = run_kind;
      end else begin
        merged[i] = ram_rdata[i];
      end
    end
  end

  always_comb begin
    xi    = XW'(qx);
    xm    = xi - 1'b1;
    xp    = xi + 1'b1;
    c_in  = (32'(qx) < CHUNK_EDGE) && (32'(qy) < CHUNK_EDGE) && (32'(qz) < LAYER_COUNT);
    xm_in = (qx != 4'd0);
    xp_in = (32'(qx) + 1) < CHUNK_EDGE;
    ym_in = (qy != 4'd0);
    yp_in = (32'(qy) + 1) < CHUNK_EDGE;
    zm_in = (qz != 4'd0);
    zp_in = (32'(qz) + 1) < LAYER_COUNT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = fill_row;
    ram_wdata  = merged;
    ram_raddr  = fill_row;
    in_stall   = 1'b1;
    res_valid  = 1'b0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == AW'(ROWS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (start_write) begin
            state_next = S_RUN;
          end else if (cmd == CMD_QUERY) begin
            state_next = S_QUERY;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_RUN: begin
        ram_we     = 1'b1;
        state_next = S_EMIT;
      end
      S_QUERY: begin
        case (qstep)
          Q_CENTER: ram_raddr = row_addr(32'(qy), 32'(qz));
          Q_YM:     ram_raddr = row_addr(32'(qy) - 1, 32'(qz));
          Q_YP:     ram_raddr = row_addr(32'(qy) + 1, 32'(qz));
          Q_ZM:     ram_raddr = row_addr(32'(qy), 32'(qz) - 1);
          Q_ZP:     ram_raddr = row_addr(32'(qy), 32'(qz) + 1);
          default:  ram_raddr = row_addr(32'(qy), 32'(qz));
        endcase
        if (qstep == QSTEPS) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      fill_x     <= '0;
      fill_y     <= '0;
      fill_layer <= '0;
      run_count  <= '0;
      done_flag  <= 1'b0;
      error_flag <= 1'b0;
      qstep      <= '0;
      rd_live    <= 1'b0;
      rd_sel     <= '0;
    end else begin
      rd_live <= (state == S_QUERY) && (qstep < QSTEPS);
      rd_sel  <= qstep;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (accept) begin
        qstep <= '0;
        case (cmd)
          CMD_START: begin
            fill_x     <= '0;
            fill_y     <= '0;
            fill_layer <= '0;
            run_count  <= '0;
            done_flag  <= 1'b0;
          end
          CMD_CHAR: begin
            if (is_digit) begin
              run_count <= digit_next;
            end else if (is_run) begin
              run_count <= '0;
              if (!done_flag && overrun) begin
                error_flag <= 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (state == S_QUERY) begin
        qstep <= qstep + 1'b1;
      end
      if (state == S_RUN) begin
        if (fill_end == CHUNK_EDGE) begin
          fill_x <= '0;
          if (fill_y == XW'(CHUNK_EDGE - 1)) begin
            fill_y <= '0;
            if (fill_layer == ZW'(LAYER_COUNT - 1)) begin
              fill_layer <= '0;
              done_flag  <= 1'b1;
            end else begin
              fill_layer <= fill_layer + 1'b1;
            end
          end else begin
            fill_y <= fill_y + 1'b1;
          end
        end else begin
          fill_x <= XW'(fill_end);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      run_kind <= (code_char == CH_SOLID);
      run_len  <= run_count;
      qx       <= query_x;
      qy       <= query_y;
      qz       <= query_z;
      is_query <= (cmd == CMD_QUERY);
    end
    if (rd_live) begin
      case (rd_sel)
        Q_CENTER: begin
          solid_c <= c_in & ram_rdata[xi];
          nb_xm   <= xm_in & ram_rdata[xm];
          nb_xp   <= xp_in & ram_rdata[xp];
        end
        Q_YM:    nb_ym <= ym_in & ram_rdata[xi];
        Q_YP:    nb_yp <= yp_in & ram_rdata[xi];
        Q_ZM:    nb_zm <= zm_in & ram_rdata[xi];
        Q_ZP:    nb_zp <= zp_in & ram_rdata[xi];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.solid        = is_query & solid_c;
    res.face_mask    = res.solid ? {~nb_xp, ~nb_xm, ~nb_zm, ~nb_zp, ~nb_yp, ~nb_ym} : 6'd0;
    res.layers_done  = done_flag;
    res.format_error = error_flag;
  end

endmodule

// File: hw/rtl/vrlf_checker.sv
// ----------------------------------------------------------------------------
// vrlf_checker
// Port-level checks of the voxel loader, bound to the top level.
// ----------------------------------------------------------------------------
module vrlf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [5:0] face_mask,
  input logic       solid,
  input logic       format_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Result item dropped while stalled.");

  a_mask_solid: assert property (@(posedge clk) disable iff (rst)
    out_valid && (face_mask != 6'd0) |-> solid)
    else $error("Visible faces reported for an air voxel.");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && format_error |=> format_error)
    else $error("Format error flag cleared without reset.");

  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> in_stall)
    else $error("Input accepted before the store was cleared.");

endmodule

bind voxel_rle_load_face_cull_unit vrlf_checker u_checker (.*);
